[rtl/core/rgb_grad_pkg.sv]
package rgb_grad_pkg;

	localparam int COORD_WIDTH     = 16;
	localparam int RATIO_FRAC_BITS = 16;
	localparam int COLOR_WIDTH     = 24;
	localparam int CHAN_WIDTH      = 8;
	localparam int CHAN_MAX        = 8'hFF;

	// coordinate difference and its square
	localparam int DIFF_WIDTH = COORD_WIDTH + 1;
	localparam int MAG_WIDTH  = COORD_WIDTH;
	localparam int SQ_WIDTH   = 2 * MAG_WIDTH;
	// sum of squares, padded to a whole number of bit pairs
	localparam int SUM_WIDTH  = SQ_WIDTH + 2;
	// floor root of the sum of squares
	localparam int ROOT_WIDTH = (SUM_WIDTH + 1) / 2;
	localparam int ROOT_CELLS = ROOT_WIDTH;
	// quotient of dc * 2^F / de
	localparam int NUM_WIDTH  = ROOT_WIDTH + RATIO_FRAC_BITS;
	localparam int QUO_WIDTH  = NUM_WIDTH;
	localparam int DIV_CELLS  = QUO_WIDTH;

	// item traveling along the root chain
	typedef struct packed {
		logic                          valid;
		logic                          bypass;
		logic [COLOR_WIDTH-1:0]        start_color;
		logic [COLOR_WIDTH-1:0]        end_color;
		logic [SUM_WIDTH-1:0]          rem_e;
		logic [ROOT_WIDTH-1:0]         root_e;
		logic [SUM_WIDTH-1:0]          rem_c;
		logic [ROOT_WIDTH-1:0]         root_c;
		logic [SUM_WIDTH-1:0]          src_e;
		logic [SUM_WIDTH-1:0]          src_c;
	} root_item_t;

	// item traveling along the divider chain
	typedef struct packed {
		logic                          valid;
		logic                          bypass;
		logic [COLOR_WIDTH-1:0]        start_color;
		logic [COLOR_WIDTH-1:0]        end_color;
		logic [ROOT_WIDTH:0]           rem;
		logic [NUM_WIDTH-1:0]          num;
		logic [QUO_WIDTH-1:0]          quo;
		logic [ROOT_WIDTH-1:0]         den;
	} div_item_t;

endpackage

[rtl/core/rgb_grad_root_cell.sv]
// one restoring root digit for both distances, one bit pair per cell
module rgb_grad_root_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rgb_grad_pkg::root_item_t in_item,
	output rgb_grad_pkg::root_item_t out_item
);
	import rgb_grad_pkg::*;

	root_item_t nxt;
	logic [SUM_WIDTH-1:0] trial_e;
	logic [SUM_WIDTH-1:0] trial_c;
	logic [1:0]           pair_e;
	logic [1:0]           pair_c;
	logic [SUM_WIDTH-1:0] src_sh_e;
	logic [SUM_WIDTH-1:0] src_sh_c;

	// shift in next bit pair of the radicand and try the digit
	always_comb begin
		nxt      = in_item;
		src_sh_e = in_item.src_e << 2;
		src_sh_c = in_item.src_c << 2;
		pair_e   = in_item.src_e[SUM_WIDTH-1 -: 2];
		pair_c   = in_item.src_c[SUM_WIDTH-1 -: 2];
		trial_e  = {in_item.rem_e[SUM_WIDTH-3:0], pair_e};
		trial_c  = {in_item.rem_c[SUM_WIDTH-3:0], pair_c};
		nxt.src_e = src_sh_e;
		nxt.src_c = src_sh_c;
		if (trial_e >= SUM_WIDTH'({in_item.root_e, 2'b01})) begin
			nxt.rem_e  = trial_e - SUM_WIDTH'({in_item.root_e, 2'b01});
			nxt.root_e = {in_item.root_e[ROOT_WIDTH-2:0], 1'b1};
		end else begin
			nxt.rem_e  = trial_e;
			nxt.root_e = {in_item.root_e[ROOT_WIDTH-2:0], 1'b0};
		end
		if (trial_c >= SUM_WIDTH'({in_item.root_c, 2'b01})) begin
			nxt.rem_c  = trial_c - SUM_WIDTH'({in_item.root_c, 2'b01});
			nxt.root_c = {in_item.root_c[ROOT_WIDTH-2:0], 1'b1};
		end else begin
			nxt.rem_c  = trial_c;
			nxt.root_c = {in_item.root_c[ROOT_WIDTH-2:0], 1'b0};
		end
	end

	// hand the item on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_item <= '0;
		end else begin
			out_item <= nxt;
		end
	end

endmodule

[rtl/core/rgb_grad_div_cell.sv]
// one restoring quotient bit per cell
module rgb_grad_div_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rgb_grad_pkg::div_item_t in_item,
	output rgb_grad_pkg::div_item_t out_item
);
	import rgb_grad_pkg::*;

	logic [ROOT_WIDTH+1:0] trial;
	logic                  take;

	// shift next numerator bit into the remainder and compare
	always_comb begin
		trial = {in_item.rem, in_item.num[NUM_WIDTH-1]};
		take  = trial >= (ROOT_WIDTH+2)'(in_item.den);
	end

	// hand the item on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_item <= '0;
		end else begin
			out_item.valid       <= in_item.valid;
			out_item.bypass      <= in_item.bypass;
			out_item.start_color <= in_item.start_color;
			out_item.end_color   <= in_item.end_color;
			out_item.den         <= in_item.den;
			out_item.num         <= in_item.num << 1;
			out_item.quo         <= {in_item.quo[QUO_WIDTH-2:0], take};
			out_item.rem         <= take
				? (ROOT_WIDTH+1)'(trial - (ROOT_WIDTH+2)'(in_item.den))
				: (ROOT_WIDTH+1)'(trial);
		end
	end

endmodule

[rtl/core/rgb_grad_blend.sv]
// channel blend: multiply stage, then add, saturate and pack
module rgb_grad_blend (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rgb_grad_pkg::div_item_t in_item,
	output logic                   done,
	output logic [rgb_grad_pkg::COLOR_WIDTH-1:0] pixel_color
);
	import rgb_grad_pkg::*;

	localparam int PROD_WIDTH = QUO_WIDTH + CHAN_WIDTH + 2;
	localparam int ACC_WIDTH  = PROD_WIDTH + 1;

	logic                         valid_s1;
	logic                         bypass_s1;
	logic [COLOR_WIDTH-1:0]       start_s1;
	logic signed [PROD_WIDTH-1:0] prod_s1 [3];
	logic [CHAN_WIDTH-1:0]        chan [3];

	// signed difference times ratio per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		bypass_s1 <= in_item.bypass;
		start_s1  <= in_item.start_color;
		for (int i = 0; i < 3; i++) begin
			prod_s1[i] <= PROD_WIDTH'(
				$signed({1'b0, in_item.end_color[i*CHAN_WIDTH +: CHAN_WIDTH]})
				- $signed({1'b0, in_item.start_color[i*CHAN_WIDTH +: CHAN_WIDTH]}))
				* $signed({1'b0, in_item.quo});
		end
	end

	// add start, floor shift and saturate
	always_comb begin
		logic signed [ACC_WIDTH-1:0] acc;
		logic [ACC_WIDTH-1:0]        q;
		for (int i = 0; i < 3; i++) begin
			acc = $signed({{(ACC_WIDTH-CHAN_WIDTH-RATIO_FRAC_BITS){1'b0}},
				start_s1[i*CHAN_WIDTH +: CHAN_WIDTH], {RATIO_FRAC_BITS{1'b0}}})
				+ ACC_WIDTH'(prod_s1[i]);
			q = ACC_WIDTH'(acc >>> RATIO_FRAC_BITS);
			if (acc < 0) begin
				chan[i] = '0;
			end else if (q > ACC_WIDTH'(CHAN_MAX)) begin
				chan[i] = CHAN_WIDTH'(CHAN_MAX);
			end else begin
				chan[i] = q[CHAN_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pixel_color <= bypass_s1 ? start_s1 : {chan[2], chan[1], chan[0]};
	end

endmodule

[rtl/core/rgb_gradient_by_distance.sv]
// start goes through s1, s2, the root cells, the divider cells and both blend registers
// throughput: one item per cycle; busy stays low, every cell hands on each cycle
// the root chain takes one bit pair per cell, the divider one quotient bit per cell
// reset: arst_n clears all valid bits and the chain cells; other payload is not reset
// done pulses for one cycle with pixel_color; the receiver cannot stall
module rgb_gradient_by_distance (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [rgb_grad_pkg::COORD_WIDTH-1:0] start_x,
	input  logic [rgb_grad_pkg::COORD_WIDTH-1:0] start_z,
	input  logic [rgb_grad_pkg::COORD_WIDTH-1:0] end_x,
	input  logic [rgb_grad_pkg::COORD_WIDTH-1:0] end_z,
	input  logic [rgb_grad_pkg::COORD_WIDTH-1:0] now_x,
	input  logic [rgb_grad_pkg::COORD_WIDTH-1:0] now_z,
	input  logic [rgb_grad_pkg::COLOR_WIDTH-1:0] start_color,
	input  logic [rgb_grad_pkg::COLOR_WIDTH-1:0] end_color,
	output logic                                 done,
	output logic [rgb_grad_pkg::COLOR_WIDTH-1:0] pixel_color
);
	import rgb_grad_pkg::*;

	logic [MAG_WIDTH-1:0] mag_s1 [4];
	logic                 valid_s1;
	logic                 same_s1;
	logic [COLOR_WIDTH-1:0] sc_s1;
	logic [COLOR_WIDTH-1:0] ec_s1;
	logic [SQ_WIDTH-1:0]  sq_s2 [4];
	logic                 valid_s2;
	logic                 same_s2;
	logic [COLOR_WIDTH-1:0] sc_s2;
	logic [COLOR_WIDTH-1:0] ec_s2;

	root_item_t root_chain [ROOT_CELLS+1];
	div_item_t  div_chain  [DIV_CELLS+1];

	assign busy = 1'b0;

	// absolute differences
	function automatic logic [MAG_WIDTH-1:0] abs_diff(
		input logic [COORD_WIDTH-1:0] a,
		input logic [COORD_WIDTH-1:0] b
	);
		logic signed [DIFF_WIDTH-1:0] d;
		d = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
		return d[DIFF_WIDTH-1] ? MAG_WIDTH'(-d) : MAG_WIDTH'(d);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1[0] <= abs_diff(end_x, start_x);
		mag_s1[1] <= abs_diff(end_z, start_z);
		mag_s1[2] <= abs_diff(now_x, start_x);
		mag_s1[3] <= abs_diff(now_z, start_z);
		same_s1   <= start_color == end_color;
		sc_s1     <= start_color;
		ec_s1     <= end_color;
		// squares
		for (int i = 0; i < 4; i++) begin
			sq_s2[i] <= SQ_WIDTH'(mag_s1[i] * mag_s1[i]);
		end
		same_s2 <= same_s1;
		sc_s2   <= sc_s1;
		ec_s2   <= ec_s1;
	end

	// feed the root chain with the sums of squares
	always_comb begin
		root_chain[0].valid       = valid_s2;
		root_chain[0].bypass      = same_s2;
		root_chain[0].start_color = sc_s2;
		root_chain[0].end_color   = ec_s2;
		root_chain[0].rem_e       = '0;
		root_chain[0].root_e      = '0;
		root_chain[0].rem_c       = '0;
		root_chain[0].root_c      = '0;
		root_chain[0].src_e       = SUM_WIDTH'({1'b0, sq_s2[0]} + {1'b0, sq_s2[1]});
		root_chain[0].src_c       = SUM_WIDTH'({1'b0, sq_s2[2]} + {1'b0, sq_s2[3]});
	end

	for (genvar g = 0; g < ROOT_CELLS; g++) begin : g_root
		rgb_grad_root_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_item  (root_chain[g]),
			.out_item (root_chain[g+1])
		);
	end

	// hand the roots to the divider chain
	always_comb begin
		div_chain[0].valid       = root_chain[ROOT_CELLS].valid;
		div_chain[0].bypass      = root_chain[ROOT_CELLS].bypass
			|| (root_chain[ROOT_CELLS].root_e == '0);
		div_chain[0].start_color = root_chain[ROOT_CELLS].start_color;
		div_chain[0].end_color   = root_chain[ROOT_CELLS].end_color;
		div_chain[0].rem         = '0;
		div_chain[0].num         = {root_chain[ROOT_CELLS].root_c, {RATIO_FRAC_BITS{1'b0}}};
		div_chain[0].quo         = '0;
		div_chain[0].den         = (root_chain[ROOT_CELLS].root_e == '0)
			? ROOT_WIDTH'(1) : root_chain[ROOT_CELLS].root_e;
	end

	for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
		rgb_grad_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_item  (div_chain[g]),
			.out_item (div_chain[g+1])
		);
	end

	rgb_grad_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_item     (div_chain[DIV_CELLS]),
		.done        (done),
		.pixel_color (pixel_color)
	);

endmodule

[rtl/core/rgb_grad_checker.sv]
// port-level checks on the gradient block
module rgb_grad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [23:0] start_color,
	input logic [23:0] end_color,
	input logic [23:0] pixel_color
);
	localparam int LAT = 54;

	// never refuses an item
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every item comes back after the fixed latency
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("missing result");

	// equal colors give the start color back
	a_same_color: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (start_color == end_color)) |-> ##LAT (pixel_color == $past(start_color, LAT)))
		else $error("equal colors altered");

	// no spurious results
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("spurious result");

endmodule

bind rgb_gradient_by_distance rgb_grad_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.start_color (start_color),
	.end_color   (end_color),
	.pixel_color (pixel_color)
);
